// ----- hw/rtl/asct_pkg.sv -----
// Package for the allocation site counting table.
// Holds sizes, request/result payload types, the stored entry type and the sequencer states.
// No dependencies.
`default_nettype none
package asct_pkg;

  localparam int ROWS    = 16;
  localparam int COLS    = 4;
  localparam int NSLOTS  = ROWS * COLS;
  localparam int ID_W    = $clog2(NSLOTS);
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int PERIOD_RESET = 60;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLAMPED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] ADDR_REPORT_PERIOD = 2'd0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] file_id;
    logic [19:0] line;
    logic [31:0] alloc_size;
    logic [15:0] site_in;
    logic [47:0] tick;
  } req_t;

  typedef struct packed {
    logic [15:0]        site_id;
    logic [1:0]         status;
    logic [31:0]        snapshot_number;
    logic signed [31:0] outstanding;
    logic [31:0]        alloc_count;
    logic [31:0]        free_count;
    logic [31:0]        entry_size;
    logic [19:0]        entry_line;
    logic [31:0]        entry_file;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] file;
    logic [19:0] line;
    logic [31:0] size;
    logic [31:0] allocs;
    logic [31:0] frees;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,
    S_ACHK,
    S_FRD,
    S_FCHK,
    S_RRD,
    S_RCHK,
    S_TCHK,
    S_SRD,
    S_SCHK,
    S_SFLUSH
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/allocation_site_counting_table_top.sv -----
// Allocation site counting table: sequencer, config register and entry RAM.
// Depends on asct_pkg and asct_ram.
// Allocation probes its row's columns in order for a free or matching slot, slot 0 on a full row;
//   release updates one slot; a tick with a report walks all NSLOTS slots, one without does not.
// One request at a time, the next is accepted the cycle after the last result is registered;
//   each step is an entry RAM read state then a check state, and a stalled result holds it.
// Reset: written bits and the slot 0 valid flag cleared at once (unwritten entries read as
//   zero), report period 60, last report tick 0, report counter 1.
`default_nettype none
module allocation_site_counting_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire asct_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output asct_pkg::rsp_t     rsp_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import asct_pkg::*;

  state_t state, state_next;
  req_t   req;
  logic [ID_W-1:0]  id;
  logic [COL_W-1:0] col;
  logic [1:0]       stat;
  logic [31:0]      period;
  logic [47:0]      last_tick;
  logic [31:0]      report_cnt;
  logic             slot0_valid;
  logic [NSLOTS-1:0] touched;
  logic             pend_v;
  rsp_t             pend;
  rsp_t             pend_out;

  logic [$bits(ent_t)-1:0] ram_q;
  ent_t ent, ent_wr;
  logic we, emit_now, push_pend, load_pend, id_step, col_step, to_full, set_v0;
  logic out_free, sv, match, qual, report;
  logic [48:0] diff;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_REPORT_PERIOD) ? period : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= 32'(PERIOD_RESET);
    end else if (psel && penable && pwrite && paddr == ADDR_REPORT_PERIOD) begin
      period <= pwdata;
    end
  end

  // entry store
  asct_ram #(.WIDTH($bits(ent_t)), .DEPTH(NSLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(id), .wdata(ent_wr), .raddr(id), .rdata(ram_q)
  );

  // slot 0 can be marked valid by a report without a RAM write
  assign ent      = touched[id] ? ent_t'(ram_q) : '0;
  assign sv       = ent.valid || (id == ID_W'(0) && slot0_valid);
  assign match    = sv && ent.line == req.line && ent.size == req.alloc_size
                    && ent.file == req.file_id;
  assign qual     = sv && ent.allocs > 32'd2 && ent.allocs != ent.frees;
  assign out_free = !rsp_valid || !rsp_stall;
  assign diff     = {1'b0, req.tick} - {1'b0, last_tick};
  assign report   = !diff[48] && diff[47:0] >= {16'd0, period};

  function automatic rsp_t mk_rsp(ent_t e, logic [ID_W-1:0] i, logic [1:0] s,
                                  logic [31:0] snap);
    rsp_t r;
    r.site_id         = 16'(i);
    r.status          = s;
    r.snapshot_number = snap;
    r.outstanding     = e.allocs - e.frees;
    r.alloc_count     = e.allocs;
    r.free_count      = e.frees;
    r.entry_size      = e.size;
    r.entry_line      = e.line;
    r.entry_file      = e.file;
    r.last            = 1'b1;
    return r;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_data.operation)
            OP_ALLOC: state_next = S_ARD;
            OP_FREE:  state_next = S_RRD;
            OP_TICK:  state_next = S_TCHK;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_ARD:  state_next = S_ACHK;
      S_ACHK: begin
        if (!sv || match) begin
          if (out_free) state_next = S_IDLE;
        end else if (col == COL_W'(COLS - 1)) begin
          state_next = S_FRD;
        end else begin
          state_next = S_ARD;
        end
      end
      S_FRD:  state_next = S_FCHK;
      S_FCHK: if (out_free) state_next = S_IDLE;
      S_RRD:  state_next = S_RCHK;
      S_RCHK: if (out_free) state_next = S_IDLE;
      S_TCHK: state_next = report ? S_SRD : S_IDLE;
      S_SRD:  state_next = S_SCHK;
      S_SCHK: begin
        if (!(qual && pend_v && !out_free)) begin
          state_next = (id == ID_W'(NSLOTS - 1)) ? S_SFLUSH : S_SRD;
        end
      end
      S_SFLUSH: if (!pend_v || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    we        = 1'b0;
    emit_now  = 1'b0;
    push_pend = 1'b0;
    load_pend = 1'b0;
    id_step   = 1'b0;
    col_step  = 1'b0;
    to_full   = 1'b0;
    set_v0    = 1'b0;
    ent_wr    = ent;
    unique case (state)
      S_ACHK: begin
        if (!sv || match) begin
          if (out_free) begin
            we       = 1'b1;
            emit_now = 1'b1;
            if (!sv) begin
              ent_wr.valid = 1'b1;
              ent_wr.file  = req.file_id;
              ent_wr.line  = req.line;
              ent_wr.size  = req.alloc_size;
            end
            ent_wr.allocs = ent.allocs + 32'd1;
          end
        end else if (col == COL_W'(COLS - 1)) begin
          to_full = 1'b1;
        end else begin
          col_step = 1'b1;
          id_step  = 1'b1;
        end
      end
      S_FCHK: begin
        ent_wr.allocs = ent.allocs + 32'd1;
        we       = out_free;
        emit_now = out_free;
      end
      S_RCHK: begin
        ent_wr.frees = ent.frees + 32'd1;
        we       = out_free;
        emit_now = out_free;
      end
      S_SCHK: begin
        if (!(qual && pend_v && !out_free)) begin
          push_pend = qual && pend_v;
          load_pend = qual;
          id_step   = 1'b1;
        end
      end
      S_SFLUSH: begin
        push_pend = pend_v && out_free;
        set_v0    = !pend_v || out_free;
      end
      default: ;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  // held report entry, last only when flushed at the end of the walk
  always_comb begin
    pend_out      = pend;
    pend_out.last = (state == S_SFLUSH);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot0_valid <= 1'b0;
      touched     <= '0;
      rsp_valid   <= 1'b0;
      pend_v      <= 1'b0;
      last_tick   <= '0;
      report_cnt  <= 32'd1;
    end else begin
      state <= state_next;
      if (we) touched[id] <= 1'b1;
      if (emit_now || push_pend) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (load_pend) pend_v <= 1'b1;
      else if (push_pend) pend_v <= 1'b0;
      if (set_v0) begin
        slot0_valid <= 1'b1;
        last_tick   <= req.tick;
        report_cnt  <= report_cnt + 32'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req <= req_data;
      col <= '0;
      unique case (req_data.operation)
        OP_ALLOC: begin
          id   <= ID_W'((32'(req_data.line) % ROWS) * COLS);
          stat <= ST_OK;
        end
        OP_FREE: begin
          if (req_data.site_in < 16'(NSLOTS)) begin
            id   <= ID_W'(req_data.site_in);
            stat <= ST_OK;
          end else begin
            id   <= '0;
            stat <= ST_CLAMPED;
          end
        end
        default: begin
          id   <= '0;
          stat <= ST_OK;
        end
      endcase
    end else begin
      if (col_step) col <= col + COL_W'(1);
      if (id_step)  id  <= id + ID_W'(1);
      if (to_full) begin
        id   <= '0;
        stat <= ST_FULL;
      end
    end
    if (emit_now) rsp_data <= mk_rsp(ent_wr, id, stat, 32'd0);
    if (push_pend) rsp_data <= pend_out;
    if (load_pend) pend <= mk_rsp(ent, id, ST_OK, report_cnt);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/asct_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module asct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
